/* hw/rtl/fbsp_pkg.sv */
// Shared types and constants for the framed byte stream parser.
// No dependencies; used by every module of the block except fbsp_fifo.
`default_nettype none

package fbsp_pkg;

    // Largest payload the block will accept, whatever the limit register says.
    localparam logic [7:0] MAX_PAYLOAD = 8'd128;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PAYLOAD = 2'd1;
    localparam logic [7:0] START_BYTE_RST = 8'h01;
    localparam logic [7:0] MAX_LEN_RST    = 8'd128;

    // Depth of the queue between the parser and the result stage.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Parser phase codes.
    localparam logic [3:0] PH_HUNT = 4'd0;
    localparam logic [3:0] PH_IDH  = 4'd1;
    localparam logic [3:0] PH_IDL  = 4'd2;
    localparam logic [3:0] PH_LENH = 4'd3;
    localparam logic [3:0] PH_LENL = 4'd4;
    localparam logic [3:0] PH_TYPH = 4'd5;
    localparam logic [3:0] PH_TYPL = 4'd6;
    localparam logic [3:0] PH_HCK  = 4'd7;
    localparam logic [3:0] PH_DATA = 4'd8;
    localparam logic [3:0] PH_DCK  = 4'd9;

    // Event codes.
    localparam logic [2:0] EV_HDR  = 3'd0;
    localparam logic [2:0] EV_PAY  = 3'd1;
    localparam logic [2:0] EV_OK   = 3'd2;
    localparam logic [2:0] EV_SKIP = 3'd3;
    localparam logic [2:0] EV_LEN  = 3'd4;
    localparam logic [2:0] EV_HCK  = 3'd5;
    localparam logic [2:0] EV_DCK  = 3'd6;

    // One classified byte as it travels from the parser to the result stage.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [6:0]  payload_index;
        logic [15:0] frame_id;
        logic [7:0]  frame_len;
        logic [15:0] frame_type;
    } t_frm_rec;

endpackage

`default_nettype wire

/* hw/rtl/fbsp_fifo.sv */
// Small register queue between the parser and the result stage.
// Generic width and depth; no package dependencies.
`default_nettype none

module fbsp_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    output logic      [WIDTH-1:0] o_rd_data,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             wr_go;
    logic             rd_go;

    assign wr_go = i_wr_en && !o_full;
    assign rd_go = i_rd_en && !o_empty;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (wr_go && !rd_go) begin
            n_count = r_count + CW'(1);
        end else if (rd_go && !wr_go) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fbsp_front.sv */
// Parser front end: configuration registers and the frame state machine.
// Classifies each received byte into one record; depends on fbsp_pkg.
`default_nettype none

module fbsp_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [fbsp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [7:0]                         i_cfg_wdata,
    input  wire logic                               i_push,
    input  wire logic [7:0]                         i_rx_byte,
    input  wire logic                               i_q_full,
    output logic                                    o_q_wr,
    output fbsp_pkg::t_frm_rec                      o_q_rec
);

    logic [7:0]  r_start_byte;
    logic [7:0]  r_max_len;
    logic [3:0]  r_phase;
    logic [15:0] r_id;
    logic [15:0] r_type;
    logic [7:0]  r_len;
    logic [7:0]  r_seen;
    logic [7:0]  r_xor;
    logic [3:0]  n_phase;
    logic [15:0] n_id;
    logic [15:0] n_type;
    logic [7:0]  n_len;
    logic [7:0]  n_seen;
    logic [7:0]  n_xor;
    logic [7:0]  limit;
    logic        ended;
    logic        accept;

    assign accept = i_push && !i_q_full;
    assign o_q_wr = accept;
    assign limit  = (r_max_len > fbsp_pkg::MAX_PAYLOAD) ? fbsp_pkg::MAX_PAYLOAD : r_max_len;

    always_comb begin
        n_phase = r_phase;
        n_id    = r_id;
        n_type  = r_type;
        n_len   = r_len;
        n_seen  = r_seen;
        n_xor   = r_xor;
        ended   = 1'b0;
        o_q_rec = '0;
        o_q_rec.event_res = fbsp_pkg::EV_HDR;

        unique case (r_phase)
            fbsp_pkg::PH_IDH: begin
                n_id    = {i_rx_byte, 8'h00};
                n_xor   = r_xor ^ i_rx_byte;
                n_phase = fbsp_pkg::PH_IDL;
            end
            fbsp_pkg::PH_IDL: begin
                n_id    = r_id | {8'h00, i_rx_byte};
                n_xor   = r_xor ^ i_rx_byte;
                n_phase = fbsp_pkg::PH_LENH;
            end
            fbsp_pkg::PH_LENH: begin
                n_len   = i_rx_byte;
                n_xor   = r_xor ^ i_rx_byte;
                n_phase = fbsp_pkg::PH_LENL;
            end
            fbsp_pkg::PH_LENL: begin
                n_xor = r_xor ^ i_rx_byte;
                // A nonzero high byte is always too long and reports as 255.
                if (r_len != 8'd0 || i_rx_byte > limit) begin
                    n_len = (r_len != 8'd0) ? 8'hFF : i_rx_byte;
                    o_q_rec.event_res = fbsp_pkg::EV_LEN;
                    ended = 1'b1;
                end else begin
                    n_len   = i_rx_byte;
                    n_phase = fbsp_pkg::PH_TYPH;
                end
            end
            fbsp_pkg::PH_TYPH: begin
                n_type  = {i_rx_byte, 8'h00};
                n_xor   = r_xor ^ i_rx_byte;
                n_phase = fbsp_pkg::PH_TYPL;
            end
            fbsp_pkg::PH_TYPL: begin
                n_type  = r_type | {8'h00, i_rx_byte};
                n_xor   = r_xor ^ i_rx_byte;
                n_phase = fbsp_pkg::PH_HCK;
            end
            fbsp_pkg::PH_HCK: begin
                if (i_rx_byte != ~r_xor) begin
                    o_q_rec.event_res = fbsp_pkg::EV_HCK;
                    ended = 1'b1;
                end else begin
                    n_xor   = 8'h00;
                    n_seen  = 8'h00;
                    n_phase = (r_len == 8'd0) ? fbsp_pkg::PH_DCK : fbsp_pkg::PH_DATA;
                end
            end
            fbsp_pkg::PH_DATA: begin
                o_q_rec.event_res     = fbsp_pkg::EV_PAY;
                o_q_rec.payload_byte  = i_rx_byte;
                o_q_rec.payload_index = r_seen[6:0];
                n_xor  = r_xor ^ i_rx_byte;
                n_seen = r_seen + 8'd1;
                if (n_seen >= r_len) begin
                    n_phase = fbsp_pkg::PH_DCK;
                end
            end
            fbsp_pkg::PH_DCK: begin
                o_q_rec.event_res = (i_rx_byte == ~r_xor) ? fbsp_pkg::EV_OK
                                                          : fbsp_pkg::EV_DCK;
                ended = 1'b1;
            end
            default: begin
                // Hunting; unused phase codes behave the same way.
                if (i_rx_byte == r_start_byte) begin
                    n_id    = '0;
                    n_type  = '0;
                    n_len   = '0;
                    n_seen  = '0;
                    n_xor   = i_rx_byte;
                    n_phase = fbsp_pkg::PH_IDH;
                end else begin
                    n_phase = fbsp_pkg::PH_HUNT;
                    o_q_rec.event_res = fbsp_pkg::EV_SKIP;
                end
            end
        endcase

        // The record reports the frame fields before any end-of-frame clear.
        o_q_rec.frame_id   = n_id;
        o_q_rec.frame_len  = n_len;
        o_q_rec.frame_type = n_type;

        if (ended) begin
            n_phase = fbsp_pkg::PH_HUNT;
            n_id    = '0;
            n_type  = '0;
            n_len   = '0;
            n_seen  = '0;
            n_xor   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= fbsp_pkg::START_BYTE_RST;
            r_max_len    <= fbsp_pkg::MAX_LEN_RST;
            r_phase      <= fbsp_pkg::PH_HUNT;
            r_id         <= '0;
            r_type       <= '0;
            r_len        <= '0;
            r_seen       <= '0;
            r_xor        <= '0;
        end else begin
            if (i_cfg_we) begin
                priority case (i_cfg_addr)
                    fbsp_pkg::CFG_START_BYTE:  r_start_byte <= i_cfg_wdata;
                    fbsp_pkg::CFG_MAX_PAYLOAD: r_max_len    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_id    <= n_id;
                r_type  <= n_type;
                r_len   <= n_len;
                r_seen  <= n_seen;
                r_xor   <= n_xor;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fbsp_back.sv */
// Result stage: error and skip counters plus the output register.
// Drains the parser queue; depends on fbsp_pkg.
`default_nettype none

module fbsp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_empty,
    input  wire fbsp_pkg::t_frm_rec  i_q_rec,
    input  wire logic                i_pop,
    output logic                     o_q_rd,
    output logic                     o_empty,
    output logic [2:0]               o_event_res,
    output logic [7:0]               o_payload_byte,
    output logic [6:0]               o_payload_index,
    output logic [15:0]              o_frame_id,
    output logic [7:0]               o_frame_len,
    output logic [15:0]              o_frame_type,
    output logic [31:0]              o_skip_count,
    output logic [31:0]              o_length_error_count,
    output logic [31:0]              o_checksum_error_count
);

    logic               r_valid;
    fbsp_pkg::t_frm_rec r_rec;
    logic [31:0]        r_skip;
    logic [31:0]        r_len_err;
    logic [31:0]        r_cks_err;
    logic [31:0]        n_skip;
    logic [31:0]        n_len_err;
    logic [31:0]        n_cks_err;

    // A new record moves in when the output slot is free or being taken.
    assign o_q_rd = !i_q_empty && (!r_valid || i_pop);

    always_comb begin
        n_skip    = r_skip;
        n_len_err = r_len_err;
        n_cks_err = r_cks_err;
        if (o_q_rd) begin
            if (i_q_rec.event_res == fbsp_pkg::EV_SKIP) begin
                n_skip = r_skip + 32'd1;
            end
            if (i_q_rec.event_res == fbsp_pkg::EV_LEN) begin
                n_len_err = r_len_err + 32'd1;
            end
            if (i_q_rec.event_res == fbsp_pkg::EV_HCK ||
                i_q_rec.event_res == fbsp_pkg::EV_DCK) begin
                n_cks_err = r_cks_err + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_skip    <= '0;
            r_len_err <= '0;
            r_cks_err <= '0;
        end else begin
            if (o_q_rd) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
            r_skip    <= n_skip;
            r_len_err <= n_len_err;
            r_cks_err <= n_cks_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_rec <= i_q_rec;
        end
    end

    // Counters move only when a record is loaded, so they match the shown result.
    assign o_empty                = !r_valid;
    assign o_event_res            = r_rec.event_res;
    assign o_payload_byte         = r_rec.payload_byte;
    assign o_payload_index        = r_rec.payload_index;
    assign o_frame_id             = r_rec.frame_id;
    assign o_frame_len            = r_rec.frame_len;
    assign o_frame_type           = r_rec.frame_type;
    assign o_skip_count           = r_skip;
    assign o_length_error_count   = r_len_err;
    assign o_checksum_error_count = r_cks_err;

endmodule

`default_nettype wire

/* hw/rtl/framed_byte_stream_parser_core.sv */
// Top level of the framed byte stream parser; depends on fbsp_pkg,
// fbsp_front, fbsp_fifo and fbsp_back.
//
// Input is a queue write side: present a byte on i_rx_byte with push high;
// it is taken on any edge where full is low. Output is a queue read side:
// while empty is low the oldest result is on the o_ ports and pop takes it.
// Every byte gives exactly one result: an event code, the payload byte and
// its index on payload events, the frame fields and the three counters.
// Configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_wdata):
// index 0 is the start byte, index 1 the payload length limit.
// An accepted byte's result passes through the queue and the output register.
// The parser state machine handles one byte per cycle, so a byte may be
// pushed on every cycle while results are popped on every cycle.
// When the receiver stalls, results pile up in the queue and the output
// register; full rises once the queue holds QUEUE_DEPTH results.
// Synchronous active-low reset clears the parser to hunting, zeroes the
// counters, empties the queue and restores the register defaults.
`default_nettype none

module framed_byte_stream_parser_core #(
    parameter int unsigned QUEUE_DEPTH = fbsp_pkg::QUEUE_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fbsp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [7:0]                      i_cfg_wdata,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [2:0]                           o_event_res,
    output logic [7:0]                           o_payload_byte,
    output logic [6:0]                           o_payload_index,
    output logic [15:0]                          o_frame_id,
    output logic [7:0]                           o_frame_len,
    output logic [15:0]                          o_frame_type,
    output logic [31:0]                          o_skip_count,
    output logic [31:0]                          o_length_error_count,
    output logic [31:0]                          o_checksum_error_count
);

    localparam int unsigned REC_W = $bits(fbsp_pkg::t_frm_rec);

    logic               q_wr;
    logic               q_rd;
    logic               q_empty;
    logic               q_full;
    fbsp_pkg::t_frm_rec q_wr_rec;
    fbsp_pkg::t_frm_rec q_rd_rec;
    logic [REC_W-1:0]   q_rd_bits;

    assign full     = q_full;
    assign q_rd_rec = fbsp_pkg::t_frm_rec'(q_rd_bits);

    fbsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (q_full),
        .o_q_wr      (q_wr),
        .o_q_rec     (q_wr_rec)
    );

    fbsp_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr),
        .i_wr_data (REC_W'(q_wr_rec)),
        .i_rd_en   (q_rd),
        .o_rd_data (q_rd_bits),
        .o_empty   (q_empty),
        .o_full    (q_full)
    );

    fbsp_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_q_empty              (q_empty),
        .i_q_rec                (q_rd_rec),
        .i_pop                  (pop),
        .o_q_rd                 (q_rd),
        .o_empty                (empty),
        .o_event_res            (o_event_res),
        .o_payload_byte         (o_payload_byte),
        .o_payload_index        (o_payload_index),
        .o_frame_id             (o_frame_id),
        .o_frame_len            (o_frame_len),
        .o_frame_type           (o_frame_type),
        .o_skip_count           (o_skip_count),
        .o_length_error_count   (o_length_error_count),
        .o_checksum_error_count (o_checksum_error_count)
    );

    // A checksum failure leaving the queue shows up as a one-step count increase.
    a_cks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_rd && (q_rd_rec.event_res == fbsp_pkg::EV_HCK ||
                  q_rd_rec.event_res == fbsp_pkg::EV_DCK))
        |=> (o_checksum_error_count == $past(o_checksum_error_count) + 32'd1))
        else $error("checksum error count did not advance");

    // A skipped byte leaving the queue advances the skip counter by one.
    a_skip_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_rd && q_rd_rec.event_res == fbsp_pkg::EV_SKIP)
        |=> (o_skip_count == $past(o_skip_count) + 32'd1))
        else $error("skip count did not advance");

    // A byte written into the queue leaves it non-empty on the next cycle.
    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |=> !q_empty)
        else $error("queue lost an accepted byte");

    // A payload byte always lies inside the frame's announced length.
    a_pay_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_res == fbsp_pkg::EV_PAY)
        |-> ({1'b0, o_payload_index} < o_frame_len))
        else $error("payload index beyond frame length");

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for framed_byte_stream_parser_core.
// Depends on fbsp_pkg and the parser RTL. A predictor written inside this file
// computes each result, and a scoreboard compares it with every popped transaction.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASE_ITEMS   = 125;
    localparam int unsigned NUM_PHASES    = 6;
    localparam int unsigned DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [6:0]  payload_index;
        logic [15:0] frame_id;
        logic [7:0]  frame_len;
        logic [15:0] frame_type;
        logic [31:0] skip_count;
        logic [31:0] length_error_count;
        logic [31:0] checksum_error_count;
    } t_parse_result;

    // A directed row is a byte and, where it is obvious, the event that it must give.
    typedef struct packed {
        logic       typed;
        logic [2:0] ev;
        logic [7:0] rx;
    } t_stim_row;

    localparam t_stim_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{1'b1, fbsp_pkg::EV_SKIP, 8'hFF},
        // Frame with an empty payload: the data check byte is 0xFF.
        '{1'b0, fbsp_pkg::EV_HDR, 8'h01}, '{1'b0, fbsp_pkg::EV_HDR, 8'h12},
        '{1'b0, fbsp_pkg::EV_HDR, 8'h34}, '{1'b0, fbsp_pkg::EV_HDR, 8'h00},
        '{1'b0, fbsp_pkg::EV_HDR, 8'h00}, '{1'b0, fbsp_pkg::EV_HDR, 8'hAB},
        '{1'b0, fbsp_pkg::EV_HDR, 8'hCD}, '{1'b0, fbsp_pkg::EV_HDR, 8'hBE},
        '{1'b1, fbsp_pkg::EV_OK,  8'hFF},
        // One payload byte followed by a bad data check byte.
        '{1'b0, fbsp_pkg::EV_HDR, 8'h01}, '{1'b0, fbsp_pkg::EV_HDR, 8'h00},
        '{1'b0, fbsp_pkg::EV_HDR, 8'h05}, '{1'b0, fbsp_pkg::EV_HDR, 8'h00},
        '{1'b0, fbsp_pkg::EV_HDR, 8'h01}, '{1'b0, fbsp_pkg::EV_HDR, 8'h00},
        '{1'b0, fbsp_pkg::EV_HDR, 8'h07}, '{1'b0, fbsp_pkg::EV_HDR, 8'hFD},
        '{1'b1, fbsp_pkg::EV_PAY, 8'h80}, '{1'b1, fbsp_pkg::EV_DCK, 8'h7E},
        // A nonzero length high byte is always a length error.
        '{1'b0, fbsp_pkg::EV_HDR, 8'h01}, '{1'b0, fbsp_pkg::EV_HDR, 8'h00},
        '{1'b0, fbsp_pkg::EV_HDR, 8'h00}, '{1'b0, fbsp_pkg::EV_HDR, 8'h01},
        '{1'b1, fbsp_pkg::EV_LEN, 8'h00}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [fbsp_pkg::CFG_ADDR_W-1:0] i_cfg_addr = fbsp_pkg::CFG_START_BYTE;
    logic [7:0]                      i_cfg_wdata = 8'h00;
    logic                            push = 1'b0;
    logic                            full;
    logic [7:0]                      i_rx_byte = 8'h00;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [2:0]                      o_event_res;
    logic [7:0]                      o_payload_byte;
    logic [6:0]                      o_payload_index;
    logic [15:0]                     o_frame_id;
    logic [7:0]                      o_frame_len;
    logic [15:0]                     o_frame_type;
    logic [31:0]                     o_skip_count;
    logic [31:0]                     o_length_error_count;
    logic [31:0]                     o_checksum_error_count;

    framed_byte_stream_parser_core i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_addr             (i_cfg_addr),
        .i_cfg_wdata            (i_cfg_wdata),
        .push                   (push),
        .full                   (full),
        .i_rx_byte              (i_rx_byte),
        .empty                  (empty),
        .pop                    (pop),
        .o_event_res            (o_event_res),
        .o_payload_byte         (o_payload_byte),
        .o_payload_index        (o_payload_index),
        .o_frame_id             (o_frame_id),
        .o_frame_len            (o_frame_len),
        .o_frame_type           (o_frame_type),
        .o_skip_count           (o_skip_count),
        .o_length_error_count   (o_length_error_count),
        .o_checksum_error_count (o_checksum_error_count)
    );

    // Predictor copy of the registers and the parser state.
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_max_len;
    logic [3:0]  st_phase;
    logic [15:0] st_id;
    logic [15:0] st_type;
    logic [7:0]  st_len;
    logic [7:0]  st_seen;
    logic [7:0]  st_xor;
    logic [31:0] cnt_skip;
    logic [31:0] cnt_len_err;
    logic [31:0] cnt_ck_err;

    t_parse_result pending_events [$];
    t_parse_result check_want;
    int unsigned   mismatches = 0;
    int unsigned   cycles = 0;
    int unsigned   send_gap_pct = 0;
    int unsigned   recv_gap_pct = 0;
    int unsigned   bytes_in_phase = 0;

    function automatic void clear_frame();
        st_phase = fbsp_pkg::PH_HUNT;
        st_id    = 16'h0000;
        st_type  = 16'h0000;
        st_len   = 8'h00;
        st_seen  = 8'h00;
        st_xor   = 8'h00;
    endfunction

    function automatic void reset_model();
        cfg_start   = fbsp_pkg::START_BYTE_RST;
        cfg_max_len = fbsp_pkg::MAX_LEN_RST;
        clear_frame();
        cnt_skip    = 32'd0;
        cnt_len_err = 32'd0;
        cnt_ck_err  = 32'd0;
    endfunction

    function automatic t_parse_result classify_byte(input logic [7:0] b);
        t_parse_result r;
        logic [7:0]    lim;
        logic [7:0]    want_ck;
        logic          ended;
        r = '0;
        r.event_res = fbsp_pkg::EV_HDR;
        ended = 1'b0;
        lim = (cfg_max_len > fbsp_pkg::MAX_PAYLOAD) ? fbsp_pkg::MAX_PAYLOAD : cfg_max_len;
        want_ck = ~st_xor;
        case (st_phase)
            fbsp_pkg::PH_IDH: begin
                st_id = {b, 8'h00};
                st_xor ^= b;
                st_phase = fbsp_pkg::PH_IDL;
            end
            fbsp_pkg::PH_IDL: begin
                st_id = st_id | {8'h00, b};
                st_xor ^= b;
                st_phase = fbsp_pkg::PH_LENH;
            end
            fbsp_pkg::PH_LENH: begin
                st_len = b;
                st_xor ^= b;
                st_phase = fbsp_pkg::PH_LENL;
            end
            fbsp_pkg::PH_LENL: begin
                st_xor ^= b;
                if (st_len != 8'h00 || b > lim) begin
                    st_len = (st_len != 8'h00) ? 8'hFF : b;
                    cnt_len_err++;
                    r.event_res = fbsp_pkg::EV_LEN;
                    ended = 1'b1;
                end else begin
                    st_len = b;
                    st_phase = fbsp_pkg::PH_TYPH;
                end
            end
            fbsp_pkg::PH_TYPH: begin
                st_type = {b, 8'h00};
                st_xor ^= b;
                st_phase = fbsp_pkg::PH_TYPL;
            end
            fbsp_pkg::PH_TYPL: begin
                st_type = st_type | {8'h00, b};
                st_xor ^= b;
                st_phase = fbsp_pkg::PH_HCK;
            end
            fbsp_pkg::PH_HCK: begin
                if (b != want_ck) begin
                    cnt_ck_err++;
                    r.event_res = fbsp_pkg::EV_HCK;
                    ended = 1'b1;
                end else begin
                    st_xor = 8'h00;
                    st_seen = 8'h00;
                    st_phase = (st_len == 8'h00) ? fbsp_pkg::PH_DCK : fbsp_pkg::PH_DATA;
                end
            end
            fbsp_pkg::PH_DATA: begin
                r.event_res = fbsp_pkg::EV_PAY;
                r.payload_byte = b;
                r.payload_index = st_seen[6:0];
                st_xor ^= b;
                st_seen = st_seen + 8'd1;
                if (st_seen >= st_len) begin
                    st_phase = fbsp_pkg::PH_DCK;
                end
            end
            fbsp_pkg::PH_DCK: begin
                if (b == want_ck) begin
                    r.event_res = fbsp_pkg::EV_OK;
                end else begin
                    cnt_ck_err++;
                    r.event_res = fbsp_pkg::EV_DCK;
                end
                ended = 1'b1;
            end
            default: begin
                // Any phase code other than the frame phases behaves as hunting.
                if (b == cfg_start) begin
                    clear_frame();
                    st_xor = b;
                    st_phase = fbsp_pkg::PH_IDH;
                end else begin
                    st_phase = fbsp_pkg::PH_HUNT;
                    cnt_skip++;
                    r.event_res = fbsp_pkg::EV_SKIP;
                end
            end
        endcase
        r.frame_id = st_id;
        r.frame_len = st_len;
        r.frame_type = st_type;
        r.skip_count = cnt_skip;
        r.length_error_count = cnt_len_err;
        r.checksum_error_count = cnt_ck_err;
        if (ended) begin
            clear_frame();
        end
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[framed_byte_stream_parser_core] ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_events.size() == 0) begin
                $error("result transaction arrived with nothing expected");
                mismatches++;
            end else begin
                check_want = pending_events.pop_front();
                compare_field("event_res", 32'(check_want.event_res), 32'(o_event_res));
                compare_field("payload_byte", 32'(check_want.payload_byte),
                              32'(o_payload_byte));
                compare_field("payload_index", 32'(check_want.payload_index),
                              32'(o_payload_index));
                compare_field("frame_id", 32'(check_want.frame_id), 32'(o_frame_id));
                compare_field("frame_len", 32'(check_want.frame_len), 32'(o_frame_len));
                compare_field("frame_type", 32'(check_want.frame_type), 32'(o_frame_type));
                compare_field("skip_count", check_want.skip_count, o_skip_count);
                compare_field("length_error_count", check_want.length_error_count,
                              o_length_error_count);
                compare_field("checksum_error_count", check_want.checksum_error_count,
                              o_checksum_error_count);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b, input logic typed, input logic [2:0] ev);
        t_parse_result r;
        logic          done;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_rx_byte <= b;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            if (!full) begin
                r = classify_byte(b);
                if (typed) begin
                    r.event_res = ev;
                end
                pending_events.push_back(r);
                bytes_in_phase++;
                done = 1'b1;
            end
            @(negedge i_clk);
        end
    endtask

    // Stops pushing and waits until every expected result has been popped.
    task automatic drain();
        push <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_events.size() != 0);
    endtask

    task automatic write_reg(input logic [fbsp_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        if (idx == fbsp_pkg::CFG_START_BYTE) begin
            cfg_start = val;
        end else begin
            cfg_max_len = val;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Sends one frame, mostly well formed, sometimes broken, sometimes plain noise.
    task automatic send_frame();
        logic [7:0]  frame_q [$];
        logic [7:0]  lim;
        logic [7:0]  lenh;
        logic [7:0]  lenl;
        logic [7:0]  acc;
        logic [7:0]  b;
        logic [15:0] fid;
        logic [15:0] ftype;
        int unsigned kind;
        int unsigned n;
        lim = (cfg_max_len > fbsp_pkg::MAX_PAYLOAD) ? fbsp_pkg::MAX_PAYLOAD : cfg_max_len;
        kind = $urandom_range(0, 99);
        if (kind >= 92) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                b = ($urandom_range(0, 9) == 0) ? cfg_start : 8'($urandom);
                frame_q.push_back(b);
            end
        end else begin
            fid = 16'($urandom);
            ftype = 16'($urandom);
            lenh = 8'h00;
            if (kind >= 86) begin
                lenh = 8'($urandom_range(1, 255));
                lenl = 8'($urandom);
            end else if (kind >= 78) begin
                lenl = 8'($urandom_range(32'(lim) + 1, 255));
            end else if (lim == 8'h00) begin
                lenl = 8'h00;
            end else if ($urandom_range(0, 15) == 0) begin
                lenl = lim;
            end else begin
                lenl = 8'($urandom_range(0, (lim < 8'd8) ? 32'(lim) : 8));
            end
            frame_q.push_back(cfg_start);
            frame_q.push_back(fid[15:8]);
            frame_q.push_back(fid[7:0]);
            frame_q.push_back(lenh);
            frame_q.push_back(lenl);
            // Length errors end the frame at the low length byte.
            if (kind < 78) begin
                frame_q.push_back(ftype[15:8]);
                frame_q.push_back(ftype[7:0]);
                acc = 8'h00;
                foreach (frame_q[i]) begin
                    acc ^= frame_q[i];
                end
                acc = ~acc;
                if (kind >= 70) begin
                    acc ^= 8'($urandom_range(1, 255));
                end
                frame_q.push_back(acc);
                if (kind < 70) begin
                    acc = 8'h00;
                    repeat (lenl) begin
                        b = 8'($urandom);
                        frame_q.push_back(b);
                        acc ^= b;
                    end
                    acc = ~acc;
                    if ($urandom_range(0, 9) == 0) begin
                        acc ^= 8'($urandom_range(1, 255));
                    end
                    frame_q.push_back(acc);
                end
            end
        end
        foreach (frame_q[i]) begin
            send_byte(frame_q[i], 1'b0, fbsp_pkg::EV_HDR);
        end
    endtask

    initial begin
        logic [7:0] start_val;
        logic [7:0] len_val;
        logic       paused;
        reset_model();
        send_gap_pct = 8;
        recv_gap_pct = 51;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].ev);
        end
        paused = 1'b0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p < 2) begin
                send_gap_pct = 8;
                recv_gap_pct = 51;
            end else if (p < 4) begin
                send_gap_pct = 51;
                recv_gap_pct = 8;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            case (p)
                0: begin
                    start_val = 8'h00;
                    len_val = 8'd0;
                end
                1: begin
                    start_val = 8'hFF;
                    len_val = 8'd255;
                end
                2: begin
                    start_val = 8'($urandom);
                    len_val = 8'd128;
                end
                3: begin
                    start_val = 8'($urandom);
                    len_val = 8'($urandom_range(1, 8));
                end
                4: begin
                    start_val = 8'($urandom);
                    len_val = 8'd129;
                end
                default: begin
                    start_val = 8'($urandom);
                    len_val = 8'($urandom);
                end
            endcase
            write_reg(fbsp_pkg::CFG_START_BYTE, start_val);
            write_reg(fbsp_pkg::CFG_MAX_PAYLOAD, len_val);
            bytes_in_phase = 0;
            while (bytes_in_phase < PHASE_ITEMS) begin
                send_frame();
                // Once mid-run, hold the input until the output side has caught up.
                if (p == 2 && !paused && bytes_in_phase >= PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end
        drain();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("[framed_byte_stream_parser_core] OK");
        end else begin
            $display("[framed_byte_stream_parser_core] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* framed_byte_stream_parser_core.f */
hw/rtl/fbsp_pkg.sv
hw/rtl/fbsp_fifo.sv
hw/rtl/fbsp_front.sv
hw/rtl/fbsp_back.sv
hw/rtl/framed_byte_stream_parser_core.sv
test/testbench.sv
